// ===== hdl/m3e_pkg.sv =====
package m3e_pkg;

  localparam int unsigned GROUP_SIZE = 3;
  localparam int unsigned POS_W      = 2;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned AVG_W      = 24;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned WEIGHT_W   = 9;
  localparam int unsigned LIMIT_W    = 10;
  localparam int unsigned OFFSET_W   = 10;
  localparam int unsigned DUTY_W     = 11;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(GROUP_SIZE - 1);

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(256);

  localparam logic [WEIGHT_W-1:0] SMOOTHING_WEIGHT_RST = WEIGHT_W'(77);
  localparam logic [LIMIT_W-1:0]  NEAR_LIMIT_RST       = LIMIT_W'(50);
  localparam logic [OFFSET_W-1:0] DUTY_OFFSET_RST      = OFFSET_W'(20);
  localparam logic [DUTY_W-1:0]   FAR_DUTY_RST         = DUTY_W'(75);

  typedef enum logic [1:0] {
    REG_SMOOTHING_WEIGHT = 2'd0,
    REG_NEAR_LIMIT       = 2'd1,
    REG_DUTY_OFFSET      = 2'd2,
    REG_FAR_DUTY         = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] smoothing_weight;
    logic [LIMIT_W-1:0]  near_limit;
    logic [OFFSET_W-1:0] duty_offset;
    logic [DUTY_W-1:0]   far_duty;
  } cfg_t;

endpackage

// ===== hdl/m3e_median.sv =====
module m3e_median (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [m3e_pkg::DIST_W-1:0]  reading,
  output logic                        close,
  output logic [m3e_pkg::DIST_W-1:0]  median
);

  logic [m3e_pkg::POS_W-1:0]  group_position;
  logic [m3e_pkg::DIST_W-1:0] held0;
  logic [m3e_pkg::DIST_W-1:0] held1;
  logic [m3e_pkg::DIST_W-1:0] lo_ab;
  logic [m3e_pkg::DIST_W-1:0] hi_ab;
  logic [m3e_pkg::DIST_W-1:0] lo_hc;

  assign close = (group_position >= m3e_pkg::LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= '0;
    end else if (step) begin
      if (close) begin
        group_position <= '0;
      end else begin
        group_position <= group_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !close) begin
      if (group_position[0]) begin
        held1 <= reading;
      end else begin
        held0 <= reading;
      end
    end
  end

  always_comb begin
    lo_ab  = (held0 < held1) ? held0 : held1;
    hi_ab  = (held0 < held1) ? held1 : held0;
    lo_hc  = (hi_ab < reading) ? hi_ab : reading;
    median = (lo_ab > lo_hc) ? lo_ab : lo_hc;
  end

endmodule

// ===== hdl/m3e_ema.sv =====
module m3e_ema (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          update,
  input  logic [m3e_pkg::DIST_W-1:0]    median,
  input  m3e_pkg::cfg_t                 cfg,
  output logic [m3e_pkg::DIST_W-1:0]    smoothed_distance,
  output logic [m3e_pkg::DUTY_W-1:0]    duty
);

  localparam int unsigned P1_W  = m3e_pkg::WEIGHT_W + m3e_pkg::DIST_W;
  localparam int unsigned P2_W  = m3e_pkg::WEIGHT_W + m3e_pkg::AVG_W;
  localparam int unsigned SUM_W = P2_W + 1;

  logic [m3e_pkg::AVG_W-1:0]    average_q8;
  logic [m3e_pkg::AVG_W-1:0]    average_q8_next;
  logic [m3e_pkg::AVG_W-1:0]    base;
  logic [m3e_pkg::WEIGHT_W-1:0] alpha;
  logic [m3e_pkg::WEIGHT_W-1:0] keep;
  logic [P1_W-1:0]              p1;
  logic [P2_W-1:0]              p2;
  logic [SUM_W-1:0]             sum;

  always_comb begin
    base  = (average_q8 == '0) ? {median, {m3e_pkg::FRAC_W{1'b0}}} : average_q8;
    alpha = cfg.smoothing_weight[m3e_pkg::WEIGHT_W-1] ? m3e_pkg::WEIGHT_ONE
                                                       : cfg.smoothing_weight;
    keep  = m3e_pkg::WEIGHT_ONE - alpha;
    p1    = P1_W'(alpha) * P1_W'(median);
    p2    = P2_W'(keep) * P2_W'(base);
    sum   = SUM_W'({p1, {m3e_pkg::FRAC_W{1'b0}}}) + SUM_W'(p2)
          + SUM_W'(1 << (m3e_pkg::FRAC_W - 1));
    average_q8_next = sum[m3e_pkg::FRAC_W +: m3e_pkg::AVG_W];

    smoothed_distance = average_q8_next[m3e_pkg::FRAC_W +: m3e_pkg::DIST_W];
    if (smoothed_distance < m3e_pkg::DIST_W'(cfg.near_limit)) begin
      duty = m3e_pkg::DUTY_W'(smoothed_distance[m3e_pkg::LIMIT_W-1:0])
           + m3e_pkg::DUTY_W'(cfg.duty_offset);
    end else begin
      duty = cfg.far_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_q8 <= '0;
    end else if (update) begin
      average_q8 <= average_q8_next;
    end
  end

endmodule

// ===== hdl/median3_ema_distance_to_duty.sv =====
// A reading that closes a group of three gives a result beat (it moves from the input
// register to the result register); others give none. Throughput: one reading per cycle
// while a stalled result does not hold back a closing reading; the median network, both
// weight multiplies and the duty compare sit between the input register and the result register.
// Reset is synchronous and active high: it empties both registers, clears the group
// position and the moving average, and loads the register defaults.
module median3_ema_distance_to_duty (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [m3e_pkg::DIST_W-1:0]         reading,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [m3e_pkg::DIST_W-1:0]         median_distance,
  output logic [m3e_pkg::DIST_W-1:0]         smoothed_distance,
  output logic [m3e_pkg::DUTY_W-1:0]         duty,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [m3e_pkg::ADDR_W-1:0]         paddr,
  input  logic [m3e_pkg::DATA_W-1:0]         pwdata,
  output logic [m3e_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  m3e_pkg::cfg_t              cfg;
  m3e_pkg::reg_index_t        reg_sel;
  logic                       s1_valid;
  logic [m3e_pkg::DIST_W-1:0] s1_reading;
  logic                       close;
  logic                       out_free;
  logic                       step;
  logic                       emit;
  logic                       in_accept;
  logic [m3e_pkg::DIST_W-1:0] median;
  logic [m3e_pkg::DIST_W-1:0] smooth;
  logic [m3e_pkg::DUTY_W-1:0] duty_calc;

  assign pready  = 1'b1;
  assign reg_sel = m3e_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing_weight <= m3e_pkg::SMOOTHING_WEIGHT_RST;
      cfg.near_limit       <= m3e_pkg::NEAR_LIMIT_RST;
      cfg.duty_offset      <= m3e_pkg::DUTY_OFFSET_RST;
      cfg.far_duty         <= m3e_pkg::FAR_DUTY_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        m3e_pkg::REG_SMOOTHING_WEIGHT: begin
          cfg.smoothing_weight <= pwdata[m3e_pkg::WEIGHT_W-1:0];
        end
        m3e_pkg::REG_NEAR_LIMIT: begin
          cfg.near_limit <= pwdata[m3e_pkg::LIMIT_W-1:0];
        end
        m3e_pkg::REG_DUTY_OFFSET: begin
          cfg.duty_offset <= pwdata[m3e_pkg::OFFSET_W-1:0];
        end
        m3e_pkg::REG_FAR_DUTY: begin
          cfg.far_duty <= pwdata[m3e_pkg::DUTY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      m3e_pkg::REG_SMOOTHING_WEIGHT: prdata = m3e_pkg::DATA_W'(cfg.smoothing_weight);
      m3e_pkg::REG_NEAR_LIMIT:       prdata = m3e_pkg::DATA_W'(cfg.near_limit);
      m3e_pkg::REG_DUTY_OFFSET:      prdata = m3e_pkg::DATA_W'(cfg.duty_offset);
      m3e_pkg::REG_FAR_DUTY:         prdata = m3e_pkg::DATA_W'(cfg.far_duty);
      default:                       prdata = '0;
    endcase
  end

  // A reading that only fills the group never waits on the result side.
  assign out_free  = !out_valid || !out_stall;
  assign step      = s1_valid && (!close || out_free);
  assign emit      = step && close;
  assign in_stall  = s1_valid && !step;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_reading <= reading;
    end
  end

  m3e_median u_median (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .reading (s1_reading),
    .close   (close),
    .median  (median)
  );

  m3e_ema u_ema (
    .clk               (clk),
    .rst               (rst),
    .update            (emit),
    .median            (median),
    .cfg               (cfg),
    .smoothed_distance (smooth),
    .duty              (duty_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      median_distance   <= median;
      smoothed_distance <= smooth;
      duty              <= duty_calc;
    end
  end

endmodule
